@@ design/sfp_pkg.sv @@
// ----------------------------------------------------------------------------
// sfp_pkg
// Shared types and codes for the serial frame parser: phase codes, report
// status codes, item kinds, register indexes and reset values, and the result record handed from the parser core.
// ----------------------------------------------------------------------------
`default_nettype none

package sfp_pkg;

  localparam int ByteW  = 8;
  localparam int PhaseW = 4;
  localparam int StatW  = 3;
  localparam int CkW    = 16;

  // Parser phases
  localparam logic [PhaseW-1:0] PH_HEAD0   = 4'd0;
  localparam logic [PhaseW-1:0] PH_HEAD1   = 4'd1;
  localparam logic [PhaseW-1:0] PH_LEN     = 4'd2;
  localparam logic [PhaseW-1:0] PH_DIR     = 4'd3;
  localparam logic [PhaseW-1:0] PH_ACC     = 4'd4;
  localparam logic [PhaseW-1:0] PH_CMD     = 4'd5;
  localparam logic [PhaseW-1:0] PH_PARAM   = 4'd6;
  localparam logic [PhaseW-1:0] PH_PAYLOAD = 4'd7;
  localparam logic [PhaseW-1:0] PH_CKLO    = 4'd8;
  localparam logic [PhaseW-1:0] PH_CKHI    = 4'd9;
  localparam logic [PhaseW-1:0] PH_DROP    = 4'd10;

  // Report status
  localparam logic [StatW-1:0] ST_OK         = 3'd0;
  localparam logic [StatW-1:0] ST_INCOMPLETE = 3'd1;
  localparam logic [StatW-1:0] ST_BAD_FIRST  = 3'd2;
  localparam logic [StatW-1:0] ST_BAD_SECOND = 3'd3;
  localparam logic [StatW-1:0] ST_BAD_SUM    = 3'd4;

  // Item kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_REPORT  = 1'b1;

  // Register indexes
  localparam logic REG_HEADER_FIRST  = 1'b0;
  localparam logic REG_HEADER_SECOND = 1'b1;

  localparam logic [ByteW-1:0] HEADER_FIRST_RST  = 8'h5A;
  localparam logic [ByteW-1:0] HEADER_SECOND_RST = 8'hA5;

  typedef struct packed {
    logic             item_kind;
    logic [CkW-1:0]   received_checksum;
    logic [StatW-1:0] status;
    logic [ByteW-1:0] parameter_res;
    logic [ByteW-1:0] command;
    logic [ByteW-1:0] access_kind;
    logic [ByteW-1:0] direction;
    logic [ByteW-1:0] frame_length;
    logic [ByteW-1:0] payload_index;
    logic [ByteW-1:0] payload_byte;
  } sfp_result_t;

endpackage

`default_nettype wire

@@ design/sfp_frame_fsm.sv @@
// ----------------------------------------------------------------------------
// sfp_frame_fsm
// Frame state machine: holds phase, running sum, payload count and header
// fields, and works out at most one result for each stepped byte.
// ----------------------------------------------------------------------------
`default_nettype none

module sfp_frame_fsm
  import sfp_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             step,
  input  wire logic [ByteW-1:0] rx_byte,
  input  wire logic             last_in_buffer,
  input  wire logic [ByteW-1:0] header_first,
  input  wire logic [ByteW-1:0] header_second,
  output logic                  res_valid,
  output sfp_result_t           res
);

  logic [PhaseW-1:0] phase, phase_next;
  logic [CkW-1:0]    running_sum, running_sum_next;
  logic [ByteW-1:0]  payload_count, payload_count_next;
  logic [ByteW-1:0]  held_length, held_length_next;
  logic [ByteW-1:0]  held_direction, held_direction_next;
  logic [ByteW-1:0]  held_access_kind, held_access_kind_next;
  logic [ByteW-1:0]  held_command, held_command_next;
  logic [ByteW-1:0]  held_parameter, held_parameter_next;
  logic [ByteW-1:0]  held_checksum_low, held_checksum_low_next;

  logic [CkW-1:0]    sum_add;
  logic [ByteW-1:0]  count_inc;
  logic [CkW-1:0]    rx_full;
  logic              is_report;
  logic [StatW-1:0]  rep_status;
  logic [CkW-1:0]    rep_ck;

  assign sum_add   = running_sum + {8'd0, rx_byte};
  assign count_inc = payload_count + 8'd1;
  assign rx_full   = {rx_byte, held_checksum_low};

  always_comb begin
    phase_next             = phase;
    running_sum_next       = running_sum;
    payload_count_next     = payload_count;
    held_length_next       = held_length;
    held_direction_next    = held_direction;
    held_access_kind_next  = held_access_kind;
    held_command_next      = held_command;
    held_parameter_next    = held_parameter;
    held_checksum_low_next = held_checksum_low;
    res_valid  = 1'b0;
    is_report  = 1'b0;
    rep_status = ST_OK;
    rep_ck     = '0;

    unique case (phase)
      PH_HEAD1: begin
        if (rx_byte != header_second) begin
          res_valid  = 1'b1;
          is_report  = 1'b1;
          rep_status = ST_BAD_SECOND;
          phase_next = last_in_buffer ? PH_HEAD0 : PH_DROP;
        end else begin
          phase_next = PH_LEN;
        end
      end
      PH_LEN: begin
        held_length_next = rx_byte;
        running_sum_next = sum_add;
        phase_next       = PH_DIR;
      end
      PH_DIR: begin
        held_direction_next = rx_byte;
        running_sum_next    = sum_add;
        phase_next          = PH_ACC;
      end
      PH_ACC: begin
        held_access_kind_next = rx_byte;
        running_sum_next      = sum_add;
        phase_next            = PH_CMD;
      end
      PH_CMD: begin
        held_command_next = rx_byte;
        running_sum_next  = sum_add;
        phase_next        = PH_PARAM;
      end
      PH_PARAM: begin
        held_parameter_next = rx_byte;
        running_sum_next    = sum_add;
        phase_next          = (held_length == '0) ? PH_CKLO : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        // a payload byte that closes the buffer is dropped for the report
        if (!last_in_buffer) begin
          res_valid          = 1'b1;
          running_sum_next   = sum_add;
          payload_count_next = count_inc;
          if (count_inc == held_length) begin
            phase_next = PH_CKLO;
          end
        end
      end
      PH_CKLO: begin
        held_checksum_low_next = rx_byte;
        phase_next             = PH_CKHI;
      end
      PH_CKHI: begin
        res_valid  = 1'b1;
        is_report  = 1'b1;
        rep_ck     = rx_full;
        rep_status = (rx_full == ~running_sum) ? ST_OK : ST_BAD_SUM;
        phase_next = last_in_buffer ? PH_HEAD0 : PH_DROP;
      end
      PH_DROP: begin
        if (last_in_buffer) begin
          phase_next = PH_HEAD0;
        end
      end
      default: begin
        // waiting for first header byte; clear the frame record
        running_sum_next       = '0;
        payload_count_next     = '0;
        held_length_next       = '0;
        held_direction_next    = '0;
        held_access_kind_next  = '0;
        held_command_next      = '0;
        held_parameter_next    = '0;
        held_checksum_low_next = '0;
        if (rx_byte != header_first) begin
          res_valid  = 1'b1;
          is_report  = 1'b1;
          rep_status = ST_BAD_FIRST;
          phase_next = last_in_buffer ? PH_HEAD0 : PH_DROP;
        end else begin
          phase_next = PH_HEAD1;
        end
      end
    endcase

    // buffer ends mid-frame: report incomplete instead
    if (last_in_buffer && !res_valid && phase != PH_DROP && phase != PH_CKHI) begin
      res_valid  = 1'b1;
      is_report  = 1'b1;
      rep_status = ST_INCOMPLETE;
      rep_ck     = {8'd0, held_checksum_low_next};
      phase_next = PH_HEAD0;
    end
  end

  always_comb begin
    res.item_kind         = is_report ? KIND_REPORT : KIND_PAYLOAD;
    res.payload_byte      = is_report ? 8'd0 : rx_byte;
    res.payload_index     = is_report ? payload_count_next : payload_count;
    res.frame_length      = held_length_next;
    res.direction         = held_direction_next;
    res.access_kind       = held_access_kind_next;
    res.command           = held_command_next;
    res.parameter_res     = held_parameter_next;
    res.status            = rep_status;
    res.received_checksum = rep_ck;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_HEAD0;
      running_sum       <= '0;
      payload_count     <= '0;
      held_length       <= '0;
      held_direction    <= '0;
      held_access_kind  <= '0;
      held_command      <= '0;
      held_parameter    <= '0;
      held_checksum_low <= '0;
    end else if (step) begin
      phase             <= phase_next;
      running_sum       <= running_sum_next;
      payload_count     <= payload_count_next;
      held_length       <= held_length_next;
      held_direction    <= held_direction_next;
      held_access_kind  <= held_access_kind_next;
      held_command      <= held_command_next;
      held_parameter    <= held_parameter_next;
      held_checksum_low <= held_checksum_low_next;
    end
  end

endmodule

`default_nettype wire

@@ design/serial_frame_parser.sv @@
// ----------------------------------------------------------------------------
// serial_frame_parser
// Parses header/length/checksum frames from a byte stream, one byte per item.
// Path: an accepted item lands in the input register; when it is stepped, the
// parser state and the result register update together. A stalled output
// holds the item in the input register until the result slot is free.
// Throughput: 1 item per cycle while the output is not stalled.
// Reset: rst clears the parser state, both pipeline valids and restores
// the header registers to 0x5A and 0xA5.
// ----------------------------------------------------------------------------
`default_nettype none

module serial_frame_parser
  import sfp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // input stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
  input  wire logic        s_tlast,   // last_in_buffer
  // output stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // [7:0] payload_byte, [15:8] payload_index, [23:16] frame_length,
  // [31:24] direction, [39:32] access_kind, [47:40] command,
  // [55:48] parameter_res, [58:56] status, [74:59] received_checksum
  output logic [79:0]      m_tdata,
  output logic             m_tuser,   // [0] item_kind
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [ByteW-1:0] header_first;
  logic [ByteW-1:0] header_second;
  logic             cfg_wr;

  logic             in_valid;
  logic [ByteW-1:0] in_byte;
  logic             in_last;
  logic             step;

  logic             res_valid;
  sfp_result_t      res;
  sfp_result_t      out_res;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = {24'd0, (paddr[2] == REG_HEADER_SECOND) ? header_second : header_first};

  always_ff @(posedge clk) begin
    if (rst) begin
      header_first  <= HEADER_FIRST_RST;
      header_second <= HEADER_SECOND_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_HEADER_FIRST) begin
        header_first <= pwdata[ByteW-1:0];
      end else begin
        header_second <= pwdata[ByteW-1:0];
      end
    end
  end

  // advance an item into the parser when the result slot is free
  assign step     = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  sfp_frame_fsm u_fsm (
    .clk           (clk),
    .rst           (rst),
    .step          (step),
    .rx_byte       (in_byte),
    .last_in_buffer(in_last),
    .header_first  (header_first),
    .header_second (header_second),
    .res_valid     (res_valid),
    .res           (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (step) begin
      m_tvalid <= res_valid;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_valid) begin
      out_res <= res;
    end
  end

  assign m_tuser = out_res.item_kind;
  assign m_tdata = {5'd0, out_res.received_checksum, out_res.status,
                    out_res.parameter_res, out_res.command, out_res.access_kind,
                    out_res.direction, out_res.frame_length, out_res.payload_index,
                    out_res.payload_byte};

  // a new result only appears after a buffered item was stepped
  a_result_from_item: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(in_valid))
    else $error("result appeared without a buffered item");

  // a stalled output blocks the parser and keeps the buffered item
  a_stall_holds_input: assert property (@(posedge clk) disable iff (rst)
    (in_valid && m_tvalid && !m_tready) |=> (in_valid && $stable(in_byte)))
    else $error("buffered item lost during output stall");

  // payload items carry zero status and checksum
  a_payload_clean: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == KIND_PAYLOAD) |->
      (out_res.status == ST_OK && out_res.received_checksum == '0))
    else $error("payload item carries report fields");

endmodule

`default_nettype wire
